[src/cpf_pkg.sv]
// Shared types and constants of the capture period frequency counter.
// No dependencies; every other file of the block imports this package.
package cpf_pkg;

	// Fixed field widths
	localparam int CAP_W = 16;
	localparam int FREQ_W = 28;
	localparam int PER_W = 16;
	localparam int CLK_W = 28;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_PAD_W = OUT_TDATA_W - FREQ_W - PER_W;

	// Divider sequencing: one quotient bit per step
	localparam int DIV_STEPS = FREQ_W;
	localparam int STEP_W = $clog2(DIV_STEPS + 1);

	// Configuration port
	localparam int APB_DATA_W = 32;
	localparam int ADDR_W = 3;
	localparam logic [ADDR_W-1:0] ADDR_CLOCK_HZ = 3'd0;
	localparam logic [CLK_W-1:0] CLOCK_RESET = 28'd42000000;

	// Input kinds carried on tuser
	localparam logic CMD_CAPTURE = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	// Job queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// One finished measurement
	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [PER_W-1:0]  period;
		logic              err;
	} res_t;

endpackage

[src/capture_period_frequency_counter_unit.sv]
// Capture period frequency counter: each pair of capture items yields one result,
// clock_hz divided by the wrapped capture difference; restart drops a held capture.
// A front end takes items one per cycle while the two-entry job queue has room. The
// divider then loads a job, forms the quotient one bit per cycle and registers the
// result once the output register is free; it pops no new job until that result is
// registered. Equal captures skip the divide and give error with frequency and
// period zero.
// Depends on cpf_pkg, cpf_front, cpf_fifo and cpf_div.
module capture_period_frequency_counter_unit import cpf_pkg::*; #(
	parameter int COUNTER_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [CAP_W-1:0]       s_tdata,   // [15:0] capture_value
	input  logic                   s_tuser,   // [0] command
	// output stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [27:0] frequency_hz, [43:28] period_ticks
	output logic                   m_tuser,   // [0] error
	// configuration
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);

	logic [CLK_W-1:0]     clock_hz_q;
	q_stat_t              q_stat;
	logic                 push;
	logic                 pop;
	logic [COUNTER_WIDTH:0] job_in;
	logic [COUNTER_WIDTH:0] job_out;
	res_t                 res;

	// Configuration register
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_CLOCK_HZ) ? APB_DATA_W'(clock_hz_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLOCK_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_CLOCK_HZ)) begin
			clock_hz_q <= pwdata[CLK_W-1:0];
		end
	end

	cpf_front #(.CW(COUNTER_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.push     (push),
		.job      (job_in)
	);

	cpf_fifo #(.W(COUNTER_WIDTH + 1), .DEPTH(2)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.pop    (pop),
		.rdata  (job_out),
		.q_stat (q_stat)
	);

	cpf_div #(.CW(COUNTER_WIDTH)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.job      (job_out),
		.pop      (pop),
		.clock_hz (clock_hz_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	// Pack the result
	assign m_tdata = {{OUT_PAD_W{1'b0}}, res.period, res.freq};
	assign m_tuser = res.err;

	// An error result carries zero frequency
	a_err_freq: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> res.freq == '0)
		else $error("error result with nonzero frequency");

	// An error result carries zero period
	a_err_period: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> res.period == '0)
		else $error("error result with nonzero period");

	// A full queue stays full until the divider pops
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full && !pop |=> q_stat.full)
		else $error("job queue lost an entry without a pop");

	// Only a job in the queue can be popped
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty job queue");

endmodule

[src/cpf_front.sv]
// Front end: accepts capture and restart items, pairs captures, forms the period.
// Depends on cpf_pkg; pushes one period job per completed pair into the job queue.
module cpf_front import cpf_pkg::*; #(
	parameter int CW = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [CAP_W-1:0] s_tdata,   // [15:0] capture_value
	input  logic             s_tuser,   // [0] command
	input  q_stat_t          q_stat,
	output logic             push,
	output logic [CW:0]      job        // [CW-1:0] period, [CW] error
);

	logic          accept;
	logic [CW-1:0] cap_w;
	logic [CW-1:0] period_w;
	logic          have_first_q;
	logic [CW-1:0] first_q;

	// Take an item whenever the queue has room
	assign s_tready = !q_stat.full;
	assign accept = s_tvalid && s_tready;

	// Fit the capture to the counter width and take the wrapped difference
	assign cap_w = CW'(s_tdata);
	assign period_w = cap_w - first_q;

	assign push = accept && (s_tuser == CMD_CAPTURE) && have_first_q;
	assign job = {(period_w == '0), period_w};

	// Hold the first capture of a pair; drop it on restart or after the pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_first_q <= 1'b0;
			first_q <= '0;
		end else if (accept) begin
			if (s_tuser == CMD_RESTART) begin
				have_first_q <= 1'b0;
				first_q <= '0;
			end else if (!have_first_q) begin
				have_first_q <= 1'b1;
				first_q <= cap_w;
			end else begin
				have_first_q <= 1'b0;
			end
		end
	end

endmodule

[src/cpf_fifo.sv]
// Short job queue between the pairing front end and the divider.
// Depends on cpf_pkg for the status struct; entries are plain registers.
module cpf_fifo import cpf_pkg::*; #(
	parameter int W = 17,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output q_stat_t      q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign q_stat.full = (cnt_q == FULL_CNT);
	assign q_stat.empty = (cnt_q == '0);
	assign do_push = push && !q_stat.full;
	assign do_pop = pop && !q_stat.empty;
	assign rdata = mem_q[rd_ptr_q];

	// Store the pushed job
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[src/cpf_div.sv]
// Back end: restoring divider for clock_hz / period and the result register.
// Depends on cpf_pkg; pops jobs from cpf_fifo and drives the output stream.
module cpf_div import cpf_pkg::*; #(
	parameter int CW = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  q_stat_t          q_stat,
	input  logic [CW:0]      job,
	output logic             pop,
	input  logic [CLK_W-1:0] clock_hz,
	output logic             m_tvalid,
	input  logic             m_tready,
	output res_t             res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic [CW-1:0]     div_q;
	logic              err_q;
	logic [CW-1:0]     rem_q;
	logic [FREQ_W-1:0] quo_q;
	logic              out_valid_q;
	res_t              out_q;

	logic [CW:0]       trial;
	logic              ge;
	logic [CW:0]       diff;
	logic              out_free;

	// One quotient bit per cycle: shift in the next dividend bit, try to subtract
	assign trial = {rem_q, quo_q[FREQ_W-1]};
	assign ge = (trial >= {1'b0, div_q});
	assign diff = trial - {1'b0, div_q};

	assign pop = (state_q == ST_IDLE) && !q_stat.empty;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign res = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			div_q <= '0;
			err_q <= 1'b0;
			rem_q <= '0;
			quo_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			// Drop the result once taken, unless a new one loads in its place
			if (out_valid_q && m_tready && (state_q != ST_HOLD)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						div_q <= job[CW-1:0];
						err_q <= job[CW];
						rem_q <= '0;
						step_q <= '0;
						// Equal captures skip the divide and report zero
						quo_q <= job[CW] ? '0 : clock_hz;
						state_q <= job[CW] ? ST_HOLD : ST_RUN;
					end
				end
				ST_RUN: begin
					rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
					quo_q <= {quo_q[FREQ_W-2:0], ge};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						out_q.freq <= quo_q;
						out_q.period <= PER_W'(div_q);
						out_q.err <= err_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[dv/capture_period_frequency_counter_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for capture_period_frequency_counter_unit: random and directed
// capture/restart items, clock rate changes over APB, results checked in order.
// Depends on cpf_pkg and the capture_period_frequency_counter_unit RTL.
module capture_period_frequency_counter_unit_tb;
	import cpf_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_STALL = 400;
	localparam logic [CLK_W-1:0] CLOCK_MAX = 28'd200000000;

	// Pairs captures, predicts each measurement and checks results in arrival order
	class freq_scoreboard;
		logic [CLK_W-1:0] clock_hz;
		bit               holding;
		logic [CAP_W-1:0] held_cap;
		res_t             expected_q[$];
		int               fails;

		function new();
			clock_hz = CLOCK_RESET;
			holding = 1'b0;
			held_cap = '0;
			fails = 0;
		endfunction

		function void set_clock(logic [CLK_W-1:0] value);
			clock_hz = value;
		endfunction

		// Advance the pairing state by one accepted item
		function void note_item(logic cmd, logic [CAP_W-1:0] cap);
			logic [CAP_W-1:0] span;
			res_t             meas;
			if (cmd == CMD_RESTART) begin
				holding = 1'b0;
				held_cap = '0;
				return;
			end
			if (!holding) begin
				held_cap = cap;
				holding = 1'b1;
				return;
			end
			// Difference wraps modulo 2^16
			span = cap - held_cap;
			holding = 1'b0;
			meas.period = span;
			meas.err = (span == '0);
			meas.freq = (span == '0) ? '0 : FREQ_W'(clock_hz / span);
			expected_q.push_back(meas);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result: frequency_hz %0d period_ticks %0d error %0d",
					got.freq, got.period, got.err);
				fails++;
				return;
			end
			want = expected_q.pop_front();
			if (got.freq !== want.freq) begin
				$error("frequency_hz: expected %0d, actual %0d", want.freq, got.freq);
				fails++;
			end
			if (got.period !== want.period) begin
				$error("period_ticks: expected %0d, actual %0d", want.period, got.period);
				fails++;
			end
			if (got.err !== want.err) begin
				$error("error: expected %0d, actual %0d", want.err, got.err);
				fails++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [CAP_W-1:0]       s_tdata = '0;       // [15:0] capture_value
	logic                   s_tuser = 1'b0;     // [0] command
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;            // [27:0] frequency_hz, [43:28] period_ticks
	logic                   m_tuser;            // [0] error
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [ADDR_W-1:0]      paddr = '0;
	logic [APB_DATA_W-1:0]  pwdata = '0;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	freq_scoreboard sb = new();
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  stall_pending = 1'b0;
	int  stall_left = 0;
	int  items_sent = 0;
	int  cycles = 0;

	capture_period_frequency_counter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stop the run if it hangs
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// Drive ready: random gaps, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (stall_pending) begin
			stall_pending = 1'b0;
			stall_left = LONG_STALL;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Check each accepted result
	always @(posedge clk) begin
		res_t seen;
		if (arst_n && m_tvalid && m_tready) begin
			seen.freq = m_tdata[FREQ_W-1:0];
			seen.period = m_tdata[FREQ_W+PER_W-1:FREQ_W];
			seen.err = m_tuser;
			sb.check_result(seen);
		end
	end

	// Offer one item and hold it until accepted; starts and ends at a falling edge
	task automatic send_item(logic cmd, logic [CAP_W-1:0] cap);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= cap;
		do @(posedge clk); while (!s_tready);
		sb.note_item(cmd, cap);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_pair(logic [CAP_W-1:0] first, logic [CAP_W-1:0] second);
		send_item(CMD_CAPTURE, first);
		send_item(CMD_CAPTURE, second);
	endtask

	// Drop valid and wait until every pending measurement is out and the divider is quiet
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Write the clock rate register, then read it back
	task automatic set_clock_rate(logic [CLK_W-1:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_CLOCK_HZ;
		pwdata <= APB_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_clock(value);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_W'(value)) begin
			$error("clock_hz: expected %0d, actual %0d", value, prdata);
			sb.fails++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mostly well-formed pairs with random spans, plus restarts and broken pairs
	task automatic run_random(int count);
		int               stop_at;
		int               kind;
		logic [CAP_W-1:0] first;
		logic [CAP_W-1:0] span;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			kind = $urandom_range(0, 99);
			first = CAP_W'($urandom_range(0, 65535));
			if (kind < 72) begin
				// realign first so the pair lands as one measurement
				if (sb.holding)
					send_item(CMD_RESTART, CAP_W'($urandom_range(0, 65535)));
				case ($urandom_range(0, 4))
					0: span = CAP_W'($urandom_range(1, 16));
					1: span = CAP_W'($urandom_range(1, 65535));
					2: span = CAP_W'(65535 - $urandom_range(0, 15));
					3: span = CAP_W'($urandom_range(17, 4096));
					default: span = '0;
				endcase
				send_pair(first, first + span);
			end else if (kind < 84) begin
				send_item(CMD_RESTART, first);
			end else if (kind < 93) begin
				send_item(CMD_CAPTURE, first);
			end else begin
				send_item(CMD_CAPTURE, first);
				send_item(CMD_RESTART, CAP_W'($urandom_range(0, 65535)));
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset clock rate: extremes, equal captures, wraparound, restarts
		send_idle_pct = 23;
		recv_idle_pct = 73;
		send_item(CMD_RESTART, 16'hFFFF);
		send_pair(16'h0000, 16'hFFFF);
		send_pair(16'h1234, 16'h1234);
		send_pair(16'hFFFF, 16'h0000);
		send_item(CMD_CAPTURE, 16'h8000);
		send_item(CMD_RESTART, 16'h0000);
		send_pair(16'h0001, 16'h0003);
		send_pair(16'hAAAA, 16'h5555);
		run_random(250);

		// Hold the output off while items keep coming so the input backs up
		stall_pending = 1'b1;
		run_random(40);
		wait_drained();

		// Zero clock rate gives zero frequency
		set_clock_rate('0);
		send_pair(16'h0010, 16'h0020);
		send_pair(16'h0005, 16'h0005);
		run_random(60);
		wait_drained();

		set_clock_rate(28'd1);
		send_pair(16'h0000, 16'h0001);
		send_pair(16'h0000, 16'h0002);
		run_random(60);
		wait_drained();

		// Top clock rate over the shortest and longest periods
		set_clock_rate(CLOCK_MAX);
		send_pair(16'h7FFF, 16'h8000);
		send_pair(16'h0000, 16'hFFFF);
		send_idle_pct = 73;
		recv_idle_pct = 23;
		run_random(300);
		wait_drained();

		set_clock_rate(CLK_W'($urandom_range(1, 200000000)));
		run_random(250);
		wait_drained();

		// No idling from here on
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_clock_rate(CLK_W'($urandom_range(1, 65535)));
		run_random(200);
		stall_pending = 1'b1;
		run_random(40);
		wait_drained();

		set_clock_rate(CLOCK_MAX);
		run_random(200);
		wait_drained();

		if (sb.fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
